// ----- rtl/core/sbcpu_pkg.sv -----
// ----------------------------------------------------------------------------
// sbcpu_pkg
// Shared types and codes for the 16-bit execute stage.
// ----------------------------------------------------------------------------
package sbcpu_pkg;

    localparam int REG_W        = 16;
    localparam int NUM_REGS     = 16;
    localparam int REG_AW       = 4;
    localparam int MEM_BYTES_DEF = 65536;
    localparam int PRINT_REG    = 15;

    // operation codes
    localparam logic [3:0] ACT_ADD  = 4'd0;
    localparam logic [3:0] ACT_SUB  = 4'd1;
    localparam logic [3:0] ACT_SLL  = 4'd2;
    localparam logic [3:0] ACT_SRL  = 4'd3;
    localparam logic [3:0] ACT_SRA  = 4'd4;
    localparam logic [3:0] ACT_SLT  = 4'd5;
    localparam logic [3:0] ACT_SLTU = 4'd6;
    localparam logic [3:0] ACT_XOR  = 4'd7;
    localparam logic [3:0] ACT_OR   = 4'd8;
    localparam logic [3:0] ACT_AND  = 4'd9;
    localparam logic [3:0] ACT_STR  = 4'd10;
    localparam logic [3:0] ACT_LDR  = 4'd11;
    localparam logic [3:0] ACT_LI   = 4'd12;
    localparam logic [3:0] ACT_JAL  = 4'd13;
    localparam logic [3:0] ACT_BAL  = 4'd14;

    // status codes
    localparam logic [1:0] ST_CONT  = 2'd0;
    localparam logic [1:0] ST_JUMP  = 2'd1;
    localparam logic [1:0] ST_HALT  = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    // service numbers
    localparam logic [REG_W-1:0] SVC_PRINT = 16'd0;
    localparam logic [REG_W-1:0] SVC_HALT  = 16'd1;
    localparam logic [REG_W-1:0] BR_TAKEN  = 16'd1;

    typedef struct packed {
        logic [3:0] action;
        logic [3:0] field_first;
        logic [3:0] field_second;
        logic [3:0] field_third;
        logic       is_service_call;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [REG_W-1:0] next_pc;
        logic             print_valid;
        logic [REG_W-1:0] print_value;
    } t_rsp;

endpackage

// ----- rtl/core/sbcpu_alu.sv -----
// ----------------------------------------------------------------------------
// sbcpu_alu
// Register-register arithmetic, logic, shift and compare operations.
// ----------------------------------------------------------------------------
module sbcpu_alu (
    input  logic [3:0]                  i_action,
    input  logic [sbcpu_pkg::REG_W-1:0] i_a,
    input  logic [sbcpu_pkg::REG_W-1:0] i_b,
    output logic [sbcpu_pkg::REG_W-1:0] o_result
);
    import sbcpu_pkg::*;

    logic [3:0] sh;

    assign sh = i_b[3:0];

    always_comb begin
        unique case (i_action)
            ACT_ADD:  o_result = i_a + i_b;
            ACT_SUB:  o_result = i_a - i_b;
            ACT_SLL:  o_result = i_a << sh;
            ACT_SRL:  o_result = i_a >> sh;
            ACT_SRA:  o_result = REG_W'($signed(i_a) >>> sh);
            ACT_SLT:  o_result = {{(REG_W-1){1'b0}}, $signed(i_a) < $signed(i_b)};
            ACT_SLTU: o_result = {{(REG_W-1){1'b0}}, i_a < i_b};
            ACT_XOR:  o_result = i_a ^ i_b;
            ACT_OR:   o_result = i_a | i_b;
            ACT_AND:  o_result = i_a & i_b;
            default:  o_result = '0;
        endcase
    end

endmodule

// ----- rtl/core/sixteen_bit_cpu_execute.sv -----
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute
// Execute stage: register file and halfword data memory in synchronous RAM.
// ----------------------------------------------------------------------------
// Each request passes accept (read the two source registers), a second
// register read (first-field register and r15) alongside the data memory
// read, then execute and write back. The register file has two read
// ports, so the four operands are read in two passes. Execute waits while
// the previous response is still held in the output register. After reset
// a clearing pass over all MEM_BYTES/2 halfwords zeroes the data memory and
// the register file; no request is taken until it ends.
// MEM_BYTES must be a power of two. Data memory is held as halfwords.
module sixteen_bit_cpu_execute #(
    parameter int MEM_BYTES = sbcpu_pkg::MEM_BYTES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    input  sbcpu_pkg::t_req i_req,
    output logic            o_rsp_valid,
    input  logic            i_rsp_ready,
    output sbcpu_pkg::t_rsp o_rsp
);
    import sbcpu_pkg::*;

    localparam int HW_DEPTH = MEM_BYTES / 2;
    localparam int HW_AW    = $clog2(HW_DEPTH);

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_RD2  = 2'd2;
    localparam logic [1:0] S_EXE  = 2'd3;

    logic [1:0]       r_state, n_state;
    logic [HW_AW-1:0] r_clr_cnt;
    t_req             r_req;
    logic [REG_W-1:0] r_a, r_b, r_pc;
    logic             r_out_valid;
    t_rsp             r_rsp;

    // register file
    logic [REG_W-1:0]  r_rf [NUM_REGS];
    logic [REG_W-1:0]  r_rf_qa, r_rf_qb;
    logic              rf_re, rf_we;
    logic [REG_AW-1:0] rf_raddr_a, rf_raddr_b, rf_waddr;
    logic [REG_W-1:0]  rf_wdata;

    // halfword data memory
    logic [REG_W-1:0] r_hw [HW_DEPTH];
    logic [REG_W-1:0] r_hw_q;
    logic             hw_re, hw_we;
    logic [HW_AW-1:0] hw_addr;
    logic [REG_W-1:0] hw_wdata;

    logic accept, out_free, exe_go, clearing;

    // execute results
    logic [REG_W-1:0]  alu_res, link, ex_wr_data, ex_pc;
    logic [REG_AW-1:0] ex_wr_idx;
    logic              ex_wr_en, ex_mem_we, ex_print;
    logic [1:0]        ex_status;

    assign clearing    = (r_state == S_CLR);
    assign o_req_ready = (r_state == S_IDLE);
    assign accept      = i_req_valid && o_req_ready;
    assign out_free    = !r_out_valid || i_rsp_ready;
    assign exe_go      = (r_state == S_EXE) && out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr_cnt == HW_AW'(HW_DEPTH - 1)) n_state = S_IDLE;
            S_IDLE: if (accept) n_state = S_RD2;
            S_RD2:  n_state = S_EXE;
            S_EXE:  if (exe_go) n_state = S_IDLE;
            default: n_state = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_cnt   <= '0;
            r_out_valid <= 1'b0;
            r_pc        <= '0;
        end else begin
            r_state <= n_state;
            if (clearing) r_clr_cnt <= r_clr_cnt + 1'b1;
            if (exe_go) begin
                r_out_valid <= 1'b1;
                r_pc        <= ex_pc;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
        if (r_state == S_RD2) begin
            r_a <= r_rf_qa;
            r_b <= r_rf_qb;
        end
        if (exe_go) begin
            r_rsp.status      <= ex_status;
            r_rsp.next_pc     <= ex_pc;
            r_rsp.print_valid <= ex_print;
            r_rsp.print_value <= ex_print ? r_rf_qb : '0;
        end
    end

    // first read: source registers; second read: first field and r15
    assign rf_re      = accept || (r_state == S_RD2);
    assign rf_raddr_a = (r_state == S_RD2) ? r_req.field_first  : i_req.field_second;
    assign rf_raddr_b = (r_state == S_RD2) ? REG_AW'(PRINT_REG) : i_req.field_third;
    assign rf_we      = clearing || (exe_go && ex_wr_en && (ex_wr_idx != '0));
    assign rf_waddr   = clearing ? r_clr_cnt[REG_AW-1:0] : ex_wr_idx;
    assign rf_wdata   = clearing ? '0 : ex_wr_data;

    always_ff @(posedge i_clk) begin
        if (rf_we) r_rf[rf_waddr] <= rf_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (rf_re) begin
            r_rf_qa <= r_rf[rf_raddr_a];
            r_rf_qb <= r_rf[rf_raddr_b];
        end
    end

    // address register arrives on port A in the second read cycle
    assign hw_re    = (r_state == S_RD2);
    assign hw_we    = clearing || (exe_go && ex_mem_we);
    assign hw_addr  = clearing ? r_clr_cnt :
                      (r_state == S_RD2) ? r_rf_qa[HW_AW:1] : r_a[HW_AW:1];
    assign hw_wdata = clearing ? '0 : r_rf_qa;

    always_ff @(posedge i_clk) begin
        if (hw_we) r_hw[hw_addr] <= hw_wdata;
        if (hw_re) r_hw_q <= r_hw[hw_addr];
    end

    sbcpu_alu u_alu (
        .i_action (r_req.action),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_result (alu_res)
    );

    assign link = r_pc + 16'd2;

    // in execute, port A holds the first-field register, port B holds r15
    always_comb begin
        ex_status  = ST_CONT;
        ex_wr_en   = 1'b0;
        ex_wr_idx  = r_req.field_first;
        ex_wr_data = alu_res;
        ex_mem_we  = 1'b0;
        ex_print   = 1'b0;
        unique case (r_req.action) inside
            [ACT_ADD:ACT_AND]: ex_wr_en = 1'b1;
            ACT_STR: begin
                if (r_a[0]) ex_status = ST_FAULT;
                else        ex_mem_we = 1'b1;
            end
            ACT_LDR: begin
                ex_wr_data = r_hw_q;
                if (r_a[0]) ex_status = ST_FAULT;
                else        ex_wr_en  = 1'b1;
            end
            ACT_LI: begin
                ex_wr_en   = 1'b1;
                ex_wr_data = {8'h00, r_req.field_second, r_req.field_third};
            end
            ACT_JAL: begin
                ex_wr_data = link;
                if (r_a[0]) begin
                    ex_status = ST_FAULT;
                end else begin
                    ex_wr_en  = 1'b1;
                    ex_status = ST_JUMP;
                end
            end
            ACT_BAL: begin
                ex_wr_data = link;
                ex_wr_idx  = r_req.field_third;
                if (r_req.is_service_call) begin
                    if (r_rf_qa == SVC_PRINT)     ex_print  = 1'b1;
                    else if (r_rf_qa == SVC_HALT) ex_status = ST_HALT;
                end else if (r_rf_qa == BR_TAKEN) begin
                    if (r_a[0]) begin
                        ex_status = ST_FAULT;
                    end else begin
                        ex_wr_en  = 1'b1;
                        ex_status = ST_JUMP;
                    end
                end
            end
            default: ;
        endcase
    end

    assign ex_pc = (ex_status == ST_CONT) ? link :
                   (ex_status == ST_JUMP) ? r_a  : r_pc;

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_RD2))
        else $error("request accepted without entering second read");

    a_rf_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (clearing || r_state == S_EXE))
        else $error("register write outside execute or clearing");

    a_mem_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hw_we |-> (clearing || (exe_go && r_req.action == ACT_STR && !r_a[0])))
        else $error("unexpected data memory write");

    a_pc_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> (o_rsp.next_pc == r_pc))
        else $error("held response disagrees with program counter");

    a_rsp_from_exe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> ($past(r_state) == S_EXE))
        else $error("response raised outside execute");

endmodule
